// File: hdl/tls_plaintext_record_deframer_core_macros.svh
// Assertion macros used by the checker file hdl/tprd_checker.sv.
`ifndef TLS_PLAINTEXT_RECORD_DEFRAMER_CORE_MACROS_SVH
`define TLS_PLAINTEXT_RECORD_DEFRAMER_CORE_MACROS_SVH

// Clocked property, disabled while reset is held.
`define TPRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tprd: property violated");

// A stalled word keeps its value.
`define TPRD_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> $stable(sig)) \
    else $error("tprd: stalled word changed");

`endif

// File: hdl/tprd_pkg.sv
package tprd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned VER_W      = 16;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'b1;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd16384;

  // Record content types
  localparam logic [BYTE_W-1:0] CT_CCS       = 8'd20;
  localparam logic [BYTE_W-1:0] CT_ALERT     = 8'd21;
  localparam logic [BYTE_W-1:0] CT_HANDSHAKE = 8'd22;
  localparam logic [BYTE_W-1:0] CT_APP_DATA  = 8'd23;
  localparam logic [BYTE_W-1:0] CCS_BYTE     = 8'h01;

  // Error codes
  localparam logic [CODE_W-1:0] ERR_BAD_TYPE = 2'd0;
  localparam logic [CODE_W-1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [CODE_W-1:0] ERR_EMPTY    = 2'd2;
  localparam logic [CODE_W-1:0] ERR_BAD_CCS  = 2'd3;

  typedef enum logic [6:0] {
    PH_TYPE   = 7'b0000001,
    PH_VER_HI = 7'b0000010,
    PH_VER_LO = 7'b0000100,
    PH_LEN_HI = 7'b0001000,
    PH_LEN_LO = 7'b0010000,
    PH_BODY   = 7'b0100000,
    PH_FAILED = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HANDSHAKE = 2'd0,
    KIND_ALERT     = 2'd1,
    KIND_CCS       = 2'd2,
    KIND_SKIP      = 2'd3
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              content_kind;
    logic [VER_W-1:0]  record_version;
    logic              last_in_record;
    logic              error_valid;
    logic [CODE_W-1:0] error_code;
  } result_t;

endpackage

// File: hdl/tls_plaintext_record_deframer_core.sv
// Each result word is registered from its accepted input byte into the output stage.
// Throughput: one byte per cycle while in_tready is high; the header parser is combinational next-state logic.
// A two-entry output stage (result register plus skid register) keeps in_tready
// high while one result waits; in_tready drops only when both entries are full.
// Reset (rst_n low, synchronous): parser to type byte, registers to 0 / 16384,
// output stage emptied.
module tls_plaintext_record_deframer_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [7:0] data_byte
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tprd_pkg::BYTE_W-1:0]          in_tdata,
  // out_tdata: [7:0] payload_byte, [23:8] record_version, [25:24] error_code, [31:26] zero
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tprd_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_tuser: [0] content_kind, [1] error_valid
  output logic [tprd_pkg::OUT_USER_W-1:0]      out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tprd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tprd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tprd_pkg::phase_t                  phase_r, phase_nxt;
  tprd_pkg::kind_t                   kind_r, kind_nxt;
  logic [tprd_pkg::VER_W-1:0]        ver_r, ver_nxt;
  logic [tprd_pkg::LEN_W-1:0]        left_r, left_nxt;
  logic                              skip_mode_r, skip_mode_nxt;
  logic                              ccs_ok_r, ccs_ok_nxt;
  logic [tprd_pkg::LEN_W-1:0]        max_len_r;

  tprd_pkg::result_t                 res;
  logic                              res_vld;
  tprd_pkg::result_t                 out_r, skid_r;
  logic                              out_valid_r, skid_valid_r;

  logic                              in_acc, cfg_acc, pop;
  logic [tprd_pkg::LEN_W-1:0]        len_full;
  logic                              body_last;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign in_tready = ~skid_valid_r;
  assign in_acc    = in_tvalid & in_tready;
  assign pop       = out_valid_r & out_tready;

  assign len_full  = {left_r[tprd_pkg::LEN_W-1:tprd_pkg::BYTE_W], in_tdata};
  assign body_last = (left_r <= tprd_pkg::LEN_W'(1));

  always_comb begin
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    ver_nxt       = ver_r;
    left_nxt      = left_r;
    skip_mode_nxt = skip_mode_r;
    ccs_ok_nxt    = ccs_ok_r;
    res_vld       = 1'b0;
    res.payload_byte   = in_tdata;
    res.content_kind   = kind_r[0];
    res.record_version = ver_r;
    res.last_in_record = body_last;
    res.error_valid    = 1'b0;
    res.error_code     = tprd_pkg::ERR_BAD_TYPE;

    if (in_acc) begin
      case (phase_r)
        tprd_pkg::PH_TYPE: begin
          phase_nxt = tprd_pkg::PH_VER_HI;
          if (skip_mode_r && in_tdata == tprd_pkg::CT_APP_DATA) begin
            kind_nxt = tprd_pkg::KIND_SKIP;
          end else begin
            if (skip_mode_r && in_tdata != tprd_pkg::CT_CCS) skip_mode_nxt = 1'b0;
            if (in_tdata == tprd_pkg::CT_HANDSHAKE) begin
              kind_nxt = tprd_pkg::KIND_HANDSHAKE;
            end else if (in_tdata == tprd_pkg::CT_ALERT) begin
              kind_nxt = tprd_pkg::KIND_ALERT;
            end else if (in_tdata == tprd_pkg::CT_CCS) begin
              kind_nxt = tprd_pkg::KIND_CCS;
            end else begin
              phase_nxt      = tprd_pkg::PH_FAILED;
              res_vld        = 1'b1;
              res.error_valid = 1'b1;
              res.error_code = tprd_pkg::ERR_BAD_TYPE;
            end
          end
        end
        tprd_pkg::PH_VER_HI: begin
          if (kind_r != tprd_pkg::KIND_SKIP) ver_nxt = {in_tdata, tprd_pkg::BYTE_W'(0)};
          phase_nxt = tprd_pkg::PH_VER_LO;
        end
        tprd_pkg::PH_VER_LO: begin
          if (kind_r != tprd_pkg::KIND_SKIP) begin
            ver_nxt = {ver_r[tprd_pkg::VER_W-1:tprd_pkg::BYTE_W], in_tdata};
          end
          phase_nxt = tprd_pkg::PH_LEN_HI;
        end
        tprd_pkg::PH_LEN_HI: begin
          left_nxt  = {in_tdata, tprd_pkg::BYTE_W'(0)};
          phase_nxt = tprd_pkg::PH_LEN_LO;
        end
        tprd_pkg::PH_LEN_LO: begin
          left_nxt = len_full;
          if (kind_r == tprd_pkg::KIND_SKIP) begin
            // a skipped empty record ends at its header
            phase_nxt = (len_full == '0) ? tprd_pkg::PH_TYPE : tprd_pkg::PH_BODY;
          end else if (len_full > max_len_r) begin
            phase_nxt       = tprd_pkg::PH_FAILED;
            res_vld         = 1'b1;
            res.error_valid = 1'b1;
            res.error_code  = tprd_pkg::ERR_TOO_LONG;
          end else if (len_full == '0) begin
            phase_nxt       = tprd_pkg::PH_FAILED;
            res_vld         = 1'b1;
            res.error_valid = 1'b1;
            res.error_code  = tprd_pkg::ERR_EMPTY;
          end else begin
            ccs_ok_nxt = (len_full == tprd_pkg::LEN_W'(1));
            phase_nxt  = tprd_pkg::PH_BODY;
          end
        end
        tprd_pkg::PH_BODY: begin
          left_nxt = body_last ? '0 : left_r - tprd_pkg::LEN_W'(1);
          if (body_last) phase_nxt = tprd_pkg::PH_TYPE;
          case (kind_r)
            tprd_pkg::KIND_SKIP: begin
            end
            tprd_pkg::KIND_CCS: begin
              if (body_last && !(ccs_ok_r && in_tdata == tprd_pkg::CCS_BYTE)) begin
                phase_nxt       = tprd_pkg::PH_FAILED;
                res_vld         = 1'b1;
                res.error_valid = 1'b1;
                res.error_code  = tprd_pkg::ERR_BAD_CCS;
              end
            end
            default: res_vld = 1'b1;
          endcase
        end
        tprd_pkg::PH_FAILED: begin
          // sticky: drop everything until reset
        end
        default: phase_nxt = tprd_pkg::PH_FAILED;
      endcase
    end

    // error words carry zero payload fields
    if (res.error_valid) begin
      res.payload_byte   = '0;
      res.content_kind   = 1'b0;
      res.record_version = '0;
      res.last_in_record = 1'b0;
    end

    if (cfg_acc && cfg_index == tprd_pkg::CFG_SKIP_START) skip_mode_nxt = cfg_data[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= tprd_pkg::PH_TYPE;
      kind_r       <= tprd_pkg::KIND_HANDSHAKE;
      ver_r        <= '0;
      left_r       <= '0;
      skip_mode_r  <= 1'b0;
      ccs_ok_r     <= 1'b0;
      max_len_r    <= tprd_pkg::MAX_LEN_RESET;
    end else begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      ver_r       <= ver_nxt;
      left_r      <= left_nxt;
      skip_mode_r <= skip_mode_nxt;
      ccs_ok_r    <= ccs_ok_nxt;
      if (cfg_acc && cfg_index == tprd_pkg::CFG_MAX_LEN) max_len_r <= cfg_data;
    end
  end

  // Output stage: result register backed by one skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_r       <= res;
        out_valid_r <= res_vld;
      end
    end else if (res_vld) begin
      if (out_valid_r) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end else begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.error_code, out_r.record_version, out_r.payload_byte};
  assign out_tuser  = {out_r.error_valid, out_r.content_kind};
  assign out_tlast  = out_r.last_in_record;

endmodule

// File: hdl/tprd_checker.sv
`include "tls_plaintext_record_deframer_core_macros.svh"

module tprd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [tprd_pkg::OUT_DATA_W-1:0]      out_tdata,
  input logic [tprd_pkg::OUT_USER_W-1:0]      out_tuser,
  input logic                                 out_tlast
);

  // an error word is the final word the block delivers until reset
  `TPRD_ASSERT(a_error_is_final, (out_tvalid && out_tready && out_tuser[1]) |=> !out_tvalid)

  `TPRD_ASSERT(a_error_zero_fields, (out_tvalid && out_tuser[1]) |-> (out_tdata[23:0] == 24'd0 && !out_tlast && !out_tuser[0]))

  `TPRD_ASSERT(a_payload_no_code, (out_tvalid && !out_tuser[1]) |-> (out_tdata[31:24] == 8'd0))

  `TPRD_HOLD(a_out_hold, out_tvalid, out_tready, out_tdata)

endmodule

bind tls_plaintext_record_deframer_core tprd_checker u_tprd_checker (.*);

// File: bench/tprd_stream_checker.sv
`timescale 1ns / 100ps

module tprd_stream_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // in_tdata: [7:0] data_byte
  input  logic [tprd_pkg::BYTE_W-1:0]     in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: [7:0] payload_byte, [23:8] record_version, [25:24] error_code, [31:26] zero
  input  logic [tprd_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: [0] content_kind, [1] error_valid
  input  logic [tprd_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            out_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tprd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tprd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     pending_count,
  output int unsigned                     result_count
);

  localparam int unsigned MAX_REPORTS = 10;

  tprd_pkg::phase_t                 phase;
  tprd_pkg::kind_t                  kind;
  logic [tprd_pkg::VER_W-1:0]       version_reg;
  logic [tprd_pkg::LEN_W-1:0]       remaining;
  logic [tprd_pkg::LEN_W-1:0]       len_limit;
  logic                             skip_on;
  logic                             ccs_single;
  tprd_pkg::result_t                due_words[$];
  int unsigned                      mismatches = 0;
  int unsigned                      words_checked = 0;

  function automatic tprd_pkg::result_t error_word(input logic [tprd_pkg::CODE_W-1:0] code);
    tprd_pkg::result_t r;
    r             = '0;
    r.error_valid = 1'b1;
    r.error_code  = code;
    return r;
  endfunction

  // Advance the parser by one stream byte; queue the word it produces, if any.
  task automatic deframe_byte(input logic [tprd_pkg::BYTE_W-1:0] b);
    tprd_pkg::result_t r;
    logic              fin;
    case (phase)
      tprd_pkg::PH_TYPE: begin
        phase = tprd_pkg::PH_VER_HI;
        if (skip_on && b == tprd_pkg::CT_APP_DATA) begin
          kind = tprd_pkg::KIND_SKIP;
        end else begin
          if (skip_on && b != tprd_pkg::CT_CCS) skip_on = 1'b0;
          if (b == tprd_pkg::CT_HANDSHAKE) kind = tprd_pkg::KIND_HANDSHAKE;
          else if (b == tprd_pkg::CT_ALERT) kind = tprd_pkg::KIND_ALERT;
          else if (b == tprd_pkg::CT_CCS) kind = tprd_pkg::KIND_CCS;
          else begin
            phase = tprd_pkg::PH_FAILED;
            due_words.push_back(error_word(tprd_pkg::ERR_BAD_TYPE));
          end
        end
      end
      tprd_pkg::PH_VER_HI: begin
        if (kind != tprd_pkg::KIND_SKIP) version_reg[15:8] = b;
        phase = tprd_pkg::PH_VER_LO;
      end
      tprd_pkg::PH_VER_LO: begin
        if (kind != tprd_pkg::KIND_SKIP) version_reg[7:0] = b;
        phase = tprd_pkg::PH_LEN_HI;
      end
      tprd_pkg::PH_LEN_HI: begin
        remaining = {b, 8'h00};
        phase     = tprd_pkg::PH_LEN_LO;
      end
      tprd_pkg::PH_LEN_LO: begin
        remaining[7:0] = b;
        if (kind == tprd_pkg::KIND_SKIP) begin
          phase = (remaining == '0) ? tprd_pkg::PH_TYPE : tprd_pkg::PH_BODY;
        end else if (remaining > len_limit) begin
          phase = tprd_pkg::PH_FAILED;
          due_words.push_back(error_word(tprd_pkg::ERR_TOO_LONG));
        end else if (remaining == '0) begin
          phase = tprd_pkg::PH_FAILED;
          due_words.push_back(error_word(tprd_pkg::ERR_EMPTY));
        end else begin
          ccs_single = (remaining == 16'd1);
          phase      = tprd_pkg::PH_BODY;
        end
      end
      tprd_pkg::PH_BODY: begin
        fin       = (remaining <= 16'd1);
        remaining = fin ? '0 : remaining - 16'd1;
        if (fin) phase = tprd_pkg::PH_TYPE;
        if (kind == tprd_pkg::KIND_CCS) begin
          if (fin && !(ccs_single && b == tprd_pkg::CCS_BYTE)) begin
            phase = tprd_pkg::PH_FAILED;
            due_words.push_back(error_word(tprd_pkg::ERR_BAD_CCS));
          end
        end else if (kind != tprd_pkg::KIND_SKIP) begin
          r                = '0;
          r.payload_byte   = b;
          r.content_kind   = (kind == tprd_pkg::KIND_ALERT);
          r.record_version = version_reg;
          r.last_in_record = fin;
          due_words.push_back(r);
        end
      end
      default: ;  // failed: drop everything until reset
    endcase
  endtask

  always @(posedge clk) begin
    tprd_pkg::result_t got;
    tprd_pkg::result_t want;
    if (!rst_n) begin
      phase       = tprd_pkg::PH_TYPE;
      kind        = tprd_pkg::KIND_HANDSHAKE;
      version_reg = '0;
      remaining   = '0;
      len_limit   = tprd_pkg::MAX_LEN_RESET;
      skip_on     = 1'b0;
      ccs_single  = 1'b0;
      due_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tprd_pkg::CFG_SKIP_START) skip_on = cfg_data[0];
        else if (cfg_index == tprd_pkg::CFG_MAX_LEN) len_limit = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        got.payload_byte   = out_tdata[7:0];
        got.record_version = out_tdata[23:8];
        got.error_code     = out_tdata[25:24];
        got.content_kind   = out_tuser[0];
        got.error_valid    = out_tuser[1];
        got.last_in_record = out_tlast;
        words_checked++;
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected word %0d: byte=%02h kind=%0d ver=%04h last=%0d err=%0d code=%0d",
                     words_checked, got.payload_byte, got.content_kind, got.record_version,
                     got.last_in_record, got.error_valid, got.error_code);
        end else begin
          want = due_words.pop_front();
          if (got !== want || out_tdata[31:26] !== 6'd0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("word %0d expected: byte=%02h kind=%0d ver=%04h last=%0d err=%0d code=%0d",
                       words_checked, want.payload_byte, want.content_kind, want.record_version,
                       want.last_in_record, want.error_valid, want.error_code);
              $display("word %0d actual:   byte=%02h kind=%0d ver=%04h last=%0d err=%0d code=%0d",
                       words_checked, got.payload_byte, got.content_kind, got.record_version,
                       got.last_in_record, got.error_valid, got.error_code);
              $display("word %0d pad=%02h", words_checked, out_tdata[31:26]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) deframe_byte(in_tdata);
    end
    fail_count    <= mismatches;
    pending_count <= due_words.size();
    result_count  <= words_checked;
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASE_BYTES = 50;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned TAIL_BYTES  = 24;

  // receiver stall patterns
  localparam int unsigned RX_OPEN     = 0;
  localparam int unsigned RX_HALF     = 1;
  localparam int unsigned RX_SPARSE   = 2;
  localparam int unsigned RX_PERIODIC = 3;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [tprd_pkg::BYTE_W-1:0]     in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tprd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [tprd_pkg::OUT_USER_W-1:0] out_tuser;
  logic                            out_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [tprd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tprd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned result_count;

  logic [tprd_pkg::BYTE_W-1:0] stream_q[$];
  logic                        gen_skip = 1'b0;
  logic [tprd_pkg::LEN_W-1:0]  gen_limit = tprd_pkg::MAX_LEN_RESET;
  logic                        hold_tog = 1'b0;
  int unsigned                 burst_left = 0;
  int unsigned                 bytes_sent = 0;
  int unsigned                 settings_used = 1;
  int unsigned                 cycle_count = 0;

  tls_plaintext_record_deframer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tprd_stream_checker stream_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still awaited", cycle_count, pending_count);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stall segments, plus one long hold-off on request.
  initial begin
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    logic        hold_seen;
    seg_left  = 0;
    mode      = RX_OPEN;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          mode     = $urandom_range(RX_OPEN, RX_PERIODIC);
        end
        seg_left--;
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_HALF:   out_tready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default:   out_tready <= (seg_left[1:0] != 2'b00);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [tprd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tprd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic skip, input logic [tprd_pkg::LEN_W-1:0] limit);
    write_reg(tprd_pkg::CFG_MAX_LEN, limit);
    write_reg(tprd_pkg::CFG_SKIP_START, {15'd0, skip});
    gen_skip  = skip;
    gen_limit = limit;
    settings_used++;
  endtask

  task automatic add_header(input logic [tprd_pkg::BYTE_W-1:0] ctype,
                            input logic [tprd_pkg::VER_W-1:0] ver,
                            input logic [tprd_pkg::LEN_W-1:0] len);
    stream_q.push_back(ctype);
    stream_q.push_back(ver[15:8]);
    stream_q.push_back(ver[7:0]);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
  endtask

  task automatic add_payload(input logic [tprd_pkg::LEN_W-1:0] len);
    for (int unsigned i = 0; i < len; i++) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Append one well-formed record, tracking skip mode the way the block does.
  task automatic add_random_record();
    int unsigned                pick;
    logic [tprd_pkg::VER_W-1:0] ver;
    logic [tprd_pkg::LEN_W-1:0] len;
    logic [tprd_pkg::LEN_W-1:0] cap;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 1) == 1) ver = 16'($urandom_range(0, 65535));
    else ver = 16'(16'h0300 + $urandom_range(1, 4));
    if (gen_skip && pick < 5) begin
      // discarded whole: length may exceed the limit
      if ($urandom_range(0, 7) == 0) len = 16'($urandom_range(0, 120));
      else len = 16'($urandom_range(0, 12));
      add_header(tprd_pkg::CT_APP_DATA, ver, len);
      add_payload(len);
    end else if ((gen_skip && pick < 7) || (!gen_skip && pick < 2)) begin
      add_header(tprd_pkg::CT_CCS, ver, 16'd1);
      stream_q.push_back(tprd_pkg::CCS_BYTE);
    end else begin
      cap = (gen_limit < 16'd120) ? gen_limit : 16'd120;
      if ($urandom_range(0, 9) == 0) len = cap;
      else if ($urandom_range(0, 7) == 0) len = 16'($urandom_range(1, cap));
      else len = 16'($urandom_range(1, (cap < 16'd16) ? cap : 16'd16));
      add_header(($urandom_range(0, 1) == 1) ? tprd_pkg::CT_ALERT : tprd_pkg::CT_HANDSHAKE,
                 ver, len);
      add_payload(len);
      gen_skip = 1'b0;
    end
  endtask

  // Offer the queued bytes in bursts with random gaps.
  task automatic send_stream();
    int unsigned gap;
    while (stream_q.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= stream_q.pop_front();
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      bytes_sent++;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // a dropped byte leaves no word behind; give the output stage time to settle
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [tprd_pkg::CODE_W-1:0] err_pick;
    logic [tprd_pkg::LEN_W-1:0]  limit;
    logic [tprd_pkg::BYTE_W-1:0] ctype;
    logic [tprd_pkg::BYTE_W-1:0] bad;
    logic [tprd_pkg::LEN_W-1:0]  len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: both kinds, extreme versions and payload values
    add_header(tprd_pkg::CT_HANDSHAKE, 16'h0000, 16'd2);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    add_header(tprd_pkg::CT_ALERT, 16'hFFFF, 16'd1);
    stream_q.push_back(8'hA5);
    send_stream();
    wait_drained();

    // skip mode: empty discarded record, CCS keeps skipping, no length check
    apply_settings(1'b1, 16'd1);
    add_header(tprd_pkg::CT_APP_DATA, 16'h0303, 16'd0);
    add_header(tprd_pkg::CT_CCS, 16'h0303, 16'd1);
    stream_q.push_back(tprd_pkg::CCS_BYTE);
    add_header(tprd_pkg::CT_APP_DATA, 16'h0303, 16'd3);
    add_payload(16'd3);
    send_stream();
    wait_drained();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: apply_settings(1'b0, 16'hFFFF);
        1: apply_settings(1'b1, 16'($urandom_range(1, 64)));
        2: apply_settings(1'b0, tprd_pkg::MAX_LEN_RESET);
        3: apply_settings(1'b1, 16'd1);
        4: apply_settings(1'b0, 16'($urandom_range(1, 65535)));
        default: apply_settings(1'($urandom_range(0, 1)), 16'($urandom_range(1, 300)));
      endcase
      while (stream_q.size() < PHASE_BYTES) add_random_record();
      // long receiver hold-off while the sender keeps offering
      if (p == 2) hold_tog <= ~hold_tog;
      send_stream();
      wait_drained();
    end

    // Errors are sticky until reset, so the run ends on one of them.
    err_pick = 2'($urandom_range(0, 3));
    if (err_pick == tprd_pkg::ERR_TOO_LONG && $urandom_range(0, 1) == 1) limit = '0;
    else limit = 16'($urandom_range(16, 2000));
    apply_settings(1'b0, limit);
    if (limit != '0) begin
      add_random_record();
      add_random_record();
    end
    if ($urandom_range(0, 1) == 1) len = 16'($urandom_range(0, 65535));
    else len = 16'h0302;
    case (err_pick)
      tprd_pkg::ERR_BAD_TYPE: begin
        if ($urandom_range(0, 1) == 1) begin
          ctype = tprd_pkg::CT_APP_DATA;
        end else begin
          ctype = tprd_pkg::CT_CCS;
          while (ctype >= tprd_pkg::CT_CCS && ctype <= tprd_pkg::CT_HANDSHAKE)
            ctype = 8'($urandom_range(0, 255));
        end
        stream_q.push_back(ctype);
      end
      tprd_pkg::ERR_TOO_LONG: add_header(8'(tprd_pkg::CT_CCS + $urandom_range(0, 2)), len,
                                         16'($urandom_range(limit + 1, 65535)));
      tprd_pkg::ERR_EMPTY:    add_header(8'(tprd_pkg::CT_CCS + $urandom_range(0, 2)), len,
                                         16'd0);
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          add_header(tprd_pkg::CT_CCS, len, 16'd1);
          bad = 8'($urandom_range(0, 254));
          if (bad >= tprd_pkg::CCS_BYTE) bad = bad + 8'd1;
          stream_q.push_back(bad);
        end else begin
          limit = 16'($urandom_range(2, 4));
          add_header(tprd_pkg::CT_CCS, len, limit);
          add_payload(limit);
        end
      end
    endcase
    // everything after the error is dropped
    for (int unsigned i = 0; i < TAIL_BYTES; i++) stream_q.push_back(8'($urandom_range(0, 255)));
    send_stream();
    wait_drained();

    $display("covered %0d stream bytes over %0d register settings, %0d result words checked",
             bytes_sent, settings_used, result_count);
    $display("run closed on forced error code %0d followed by %0d dropped bytes",
             err_pick, TAIL_BYTES);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d words never arrived", fail_count, pending_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
